// ===== hw/rtl/shrl_pkg.sv =====
// Shared types and constants for the shot heat estimator and rate limiter.
package shrl_pkg;

    localparam int HEAT_W    = 24;
    localparam int CNT_W     = 16;
    localparam int RATE_W    = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam logic [HEAT_W-1:0] HEAT_MAX = 24'hFFFFFF;
    localparam logic [CNT_W-1:0]  CNT_MAX  = 16'hFFFF;
    localparam logic [RATE_W-1:0] RATE_MAX = 16'hFFFF;

    // Integer heat constants, shifted into Q.F at the top level
    localparam logic [6:0] MARGIN_LARGE = 7'd105;
    localparam logic [6:0] MARGIN_SMALL = 7'd15;
    localparam logic [6:0] HEADROOM_INT = 7'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BARREL      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOT_HEAT         = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_LIMIT        = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_PER_SECOND   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_PER_TICK     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_THRESHOLD = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_IDLE_TICKS   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_TICKS     = 8'd7;

    typedef enum logic [1:0] {
        DET_STOP     = 2'd0,
        DET_PRECHECK = 2'd1,
        DET_SUSPECT  = 2'd2,
        DET_CONFIRM  = 2'd3
    } det_mode_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_TICK,
        SEQ_RATE,
        SEQ_DIV,
        SEQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [RATE_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== hw/rtl/shrl_div.sv =====
// Restoring divider giving a 16-bit quotient one bit per cycle, with overflow flag.
module shrl_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 19
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output shrl_pkg::div_rsp_t rsp
);
    import shrl_pkg::*;

    localparam int CW = ((NUM_W > DEN_W + RATE_W) ? NUM_W : DEN_W + RATE_W) + 1;
    localparam int CB = $clog2(RATE_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic [CB-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]     dsh_reg, dsh_next;
    logic [RATE_W-1:0] quot_reg, quot_next;

    logic [CW-1:0] num_ext;
    logic [CW-1:0] den_top;
    logic          ovf_now;
    logic          step_ge;

    always_comb begin
        num_ext   = CW'(num);
        den_top   = CW'(den) << RATE_W;
        ovf_now   = num_ext >= den_top;
        step_ge   = rem_reg >= dsh_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        if (start) begin
            // load the operands; if the quotient would not fit in 16 bits, flag it and finish without iterating
            rem_next  = num_ext;
            dsh_next  = CW'(den) << (RATE_W - 1);
            quot_next = '0;
            cnt_next  = CB'(RATE_W - 1);
            ovf_next  = ovf_now;
            done_next = ovf_now;
            busy_next = !ovf_now;
        end else if (busy_reg) begin
            if (step_ge) begin
                rem_next = rem_reg - dsh_reg;
            end
            quot_next = {quot_reg[RATE_W-2:0], step_ge};
            dsh_next  = dsh_reg >> 1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
        end
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quot = quot_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_start_next: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (busy_reg || done_reg))
        else $error("divider start neither ran nor finished");
    a_done_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && ovf_reg) |-> $past(start))
        else $error("overflow reported after iterating");

endmodule

// ===== hw/rtl/shot_heat_estimator_rate_limiter_top.sv =====
// Top level of the shot heat estimator and fire-rate limiter.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | current, speeds, referee heat, rates
//  m_      | out       | m_valid / m_ready  | heat estimate, safe rate, detector, shot
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// A result is offered once the heat update, rate decision, divider run and output
// load are through; a zero rate skips the divider. s_ready returns with it, so a
// new tick is taken only after the last one is done. The shared restoring divider
// gives one quotient bit per cycle.
// A result waiting in the output register does not block the next transfer, but
// the following result holds in the done state until m_ready frees the register.
// aresetn is synchronous, active low; it restores state and register defaults.
module shot_heat_estimator_rate_limiter_top #(
    parameter int HEAT_FRAC_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [15:0]                  s_wheel_current,
    input  logic signed [15:0]                  s_wheel_speed,
    input  logic signed [15:0]                  s_target_speed,
    input  logic                                s_ref_valid,
    input  logic [15:0]                         s_ref_heat,
    input  logic [15:0]                         s_desired_rate,
    input  logic [15:0]                         s_rate_ceiling,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [23:0]                         m_heat_estimate,
    output logic [15:0]                         m_safe_rate,
    output logic [1:0]                          m_detector_state,
    output logic                                m_shot_counted,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [shrl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [shrl_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import shrl_pkg::*;

    localparam int F      = HEAT_FRAC_BITS;
    localparam int RHW    = (16 + F > HEAT_W) ? 16 + F : HEAT_W;
    localparam int SW     = (8 + F > 26) ? 9 + F : 27;
    localparam int NUM_W  = 24 + F;
    localparam int DEN_W  = 19;
    localparam int HR_W   = 20;
    localparam int MUL_W  = 22;

    // configuration
    logic               large_barrel_reg;
    logic [15:0]        shot_heat_reg;
    logic [19:0]        heat_limit_reg;
    logic [15:0]        cool_per_second_reg;
    logic [15:0]        cool_per_tick_reg;
    logic signed [15:0] current_threshold_reg;
    logic [15:0]        sync_idle_ticks_reg;
    logic [15:0]        confirm_ticks_reg;

    // latched tick inputs
    logic signed [15:0] cur_reg, spd_reg, tgt_reg;
    logic               ref_valid_reg;
    logic [15:0]        ref_heat_reg, desired_reg, ceiling_reg;

    seq_state_t        state_reg, state_next;
    det_mode_t         mode_reg, mode_next;
    logic [HEAT_W-1:0] heat_reg, heat_next;
    logic [CNT_W-1:0]  idle_reg, idle_next;
    logic [CNT_W-1:0]  scnt_reg, scnt_next;
    logic              shot_reg, shot_next;
    logic              hold_reg, hold_next;
    logic [RATE_W-1:0] rate_reg, rate_next;

    logic              m_valid_reg, m_valid_next;
    logic [HEAT_W-1:0] out_heat_reg;
    logic [RATE_W-1:0] out_rate_reg;
    det_mode_t         out_mode_reg;
    logic              out_shot_reg;

    logic              out_load;
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    div_rsp_t          div_rsp;

    // tick update signals
    logic [CNT_W-1:0]         idle_inc, scnt_inc;
    logic [RHW-1:0]           rh_ext;
    logic [HEAT_W-1:0]        rh_sat, heat_a, heat_b;
    logic [HEAT_W:0]          heat_sum;
    logic signed [MUL_W-1:0]  spd20, tgt17;
    logic                     cur_high;
    det_mode_t                mode_t;
    logic [CNT_W-1:0]         scnt_t, idle_t;
    logic                     shot_t;

    // rate decision signals
    logic signed [SW-1:0] q_s, qmax_s, d_s, margin_s, headroom_s, hr_s;
    logic                 hold_zone, zero_zone, no_room, rate_zero;
    logic [HR_W-1:0]      hr_u;
    logic [23:0]          hr10;
    logic [RATE_W-1:0]    safe_min;

    // heat update and detector for one tick
    always_comb begin
        idle_inc = (idle_reg == CNT_MAX) ? idle_reg : idle_reg + 1'b1;
        rh_ext   = RHW'(ref_heat_reg) << F;
        rh_sat   = (rh_ext > RHW'(HEAT_MAX)) ? HEAT_MAX : rh_ext[HEAT_W-1:0];
        heat_a   = heat_reg;
        if (ref_valid_reg) begin
            if (heat_a < rh_sat) begin
                heat_a = rh_sat;
            end
            if (idle_inc > sync_idle_ticks_reg) begin
                heat_a = rh_sat;
            end
        end
        spd20    = MUL_W'(spd_reg) * 22'sd20;
        tgt17    = MUL_W'(tgt_reg) * 22'sd17;
        cur_high = cur_reg >= current_threshold_reg;
        scnt_inc = (scnt_reg == CNT_MAX) ? scnt_reg : scnt_reg + 1'b1;
        heat_sum = {1'b0, heat_a} + (HEAT_W + 1)'(shot_heat_reg);
        mode_t   = mode_reg;
        scnt_t   = scnt_reg;
        idle_t   = idle_inc;
        shot_t   = 1'b0;
        unique case (mode_reg)
            DET_STOP: begin
                if (spd20 > tgt17) begin
                    mode_t = DET_PRECHECK;
                    scnt_t = '0;
                end
            end
            DET_PRECHECK: begin
                if (cur_high) begin
                    mode_t = DET_SUSPECT;
                    scnt_t = '0;
                end
            end
            DET_SUSPECT: begin
                if (!cur_high) begin
                    scnt_t = scnt_inc;
                    if (scnt_inc > confirm_ticks_reg) begin
                        mode_t = DET_CONFIRM;
                        scnt_t = '0;
                    end
                end else begin
                    scnt_t = '0;
                end
            end
            DET_CONFIRM: begin
                heat_a = heat_sum[HEAT_W] ? HEAT_MAX : heat_sum[HEAT_W-1:0];
                idle_t = '0;
                mode_t = DET_PRECHECK;
                scnt_t = '0;
                shot_t = 1'b1;
            end
        endcase
        heat_b = (heat_a > HEAT_W'(cool_per_tick_reg)) ?
                 heat_a - HEAT_W'(cool_per_tick_reg) : '0;
    end

    // rate decision on the updated estimate
    always_comb begin
        q_s        = $signed(SW'(heat_reg));
        qmax_s     = $signed(SW'(heat_limit_reg));
        d_s        = $signed(SW'(shot_heat_reg));
        margin_s   = $signed(SW'(large_barrel_reg ? MARGIN_LARGE : MARGIN_SMALL) << F);
        headroom_s = $signed(SW'(HEADROOM_INT) << F);
        hold_zone  = q_s >= (qmax_s - margin_s);
        zero_zone  = (q_s <<< 1) >= ((qmax_s <<< 1) - d_s);
        hr_s       = qmax_s - q_s - headroom_s;
        no_room    = hr_s <= 0;
        rate_zero  = hold_zone ? zero_zone : no_room;
        hr_u       = hr_s[HR_W-1:0];
        hr10       = (24'(hr_u) << 3) + (24'(hr_u) << 1);
        if (hold_zone) begin
            div_num = NUM_W'(cool_per_second_reg) << (F + 2);
            div_den = (DEN_W'(shot_heat_reg) << 2) + DEN_W'(shot_heat_reg);
        end else begin
            div_num = NUM_W'(hr10) << F;
            div_den = DEN_W'(shot_heat_reg);
        end
        // overflow means the safe limit is above any 16-bit request
        safe_min = desired_reg;
        if (!div_rsp.ovf && (div_rsp.quot < safe_min)) begin
            safe_min = div_rsp.quot;
        end
        if (safe_min > ceiling_reg) begin
            safe_min = ceiling_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: if (s_valid)      state_next = SEQ_TICK;
            SEQ_TICK:                   state_next = SEQ_RATE;
            SEQ_RATE: state_next = rate_zero ? SEQ_DONE : SEQ_DIV;
            SEQ_DIV:  if (div_rsp.done) state_next = SEQ_DONE;
            SEQ_DONE: if (out_load)     state_next = SEQ_IDLE;
            default:                    state_next = SEQ_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = state_reg == SEQ_IDLE;
        div_start = (state_reg == SEQ_RATE) && !rate_zero;
        out_load  = (state_reg == SEQ_DONE) && (!m_valid_reg || m_ready);
    end

    // datapath next values
    always_comb begin
        mode_next    = mode_reg;
        heat_next    = heat_reg;
        idle_next    = idle_reg;
        scnt_next    = scnt_reg;
        shot_next    = shot_reg;
        hold_next    = hold_reg;
        rate_next    = rate_reg;
        m_valid_next = m_valid_reg;
        if (state_reg == SEQ_TICK) begin
            mode_next = mode_t;
            heat_next = heat_b;
            idle_next = idle_t;
            scnt_next = scnt_t;
            shot_next = shot_t;
        end
        if (state_reg == SEQ_RATE) begin
            hold_next = hold_zone;
            rate_next = '0;
        end
        if ((state_reg == SEQ_DIV) && div_rsp.done) begin
            if (hold_reg) begin
                rate_next = div_rsp.ovf ? RATE_MAX : div_rsp.quot;
            end else begin
                rate_next = safe_min;
            end
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= SEQ_IDLE;
            mode_reg              <= DET_STOP;
            heat_reg              <= '0;
            idle_reg              <= '0;
            scnt_reg              <= '0;
            m_valid_reg           <= 1'b0;
            large_barrel_reg      <= 1'b0;
            shot_heat_reg         <= 16'd2560;
            heat_limit_reg        <= 20'd22528;
            cool_per_second_reg   <= 16'd6144;
            cool_per_tick_reg     <= 16'd6;
            current_threshold_reg <= 16'sd3000;
            sync_idle_ticks_reg   <= 16'd300;
            confirm_ticks_reg     <= 16'd15;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            heat_reg    <= heat_next;
            idle_reg    <= idle_next;
            scnt_reg    <= scnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                // drop writes to indexes beyond the register list
                unique case (cfg_index)
                    CFG_LARGE_BARREL:      large_barrel_reg      <= cfg_data[0];
                    CFG_SHOT_HEAT:         shot_heat_reg         <= cfg_data[15:0];
                    CFG_HEAT_LIMIT:        heat_limit_reg        <= cfg_data[19:0];
                    CFG_COOL_PER_SECOND:   cool_per_second_reg   <= cfg_data[15:0];
                    CFG_COOL_PER_TICK:     cool_per_tick_reg     <= cfg_data[15:0];
                    CFG_CURRENT_THRESHOLD: current_threshold_reg <= $signed(cfg_data[15:0]);
                    CFG_SYNC_IDLE_TICKS:   sync_idle_ticks_reg   <= cfg_data[15:0];
                    CFG_CONFIRM_TICKS:     confirm_ticks_reg     <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        shot_reg <= shot_next;
        hold_reg <= hold_next;
        rate_reg <= rate_next;
        if (s_valid && s_ready) begin
            cur_reg       <= s_wheel_current;
            spd_reg       <= s_wheel_speed;
            tgt_reg       <= s_target_speed;
            ref_valid_reg <= s_ref_valid;
            ref_heat_reg  <= s_ref_heat;
            desired_reg   <= s_desired_rate;
            ceiling_reg   <= s_rate_ceiling;
        end
        if (out_load) begin
            out_heat_reg <= heat_reg;
            out_rate_reg <= rate_reg;
            out_mode_reg <= mode_reg;
            out_shot_reg <= shot_reg;
        end
    end

    shrl_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .rsp     (div_rsp)
    );

    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_heat_estimate  = out_heat_reg;
    assign m_safe_rate      = out_rate_reg;
    assign m_detector_state = out_mode_reg;
    assign m_shot_counted   = out_shot_reg;

    a_shot_precheck: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_shot_counted) |-> (m_detector_state == DET_PRECHECK))
        else $error("shot reported outside precheck");
    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == SEQ_DIV))
        else $error("divider result outside divide step");
    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_IDLE && $past(state_reg) == SEQ_DONE) |-> m_valid_reg)
        else $error("result not loaded on leaving done");
    a_tick_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == SEQ_TICK))
        else $error("transfer did not start a tick");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the shot heat estimator and fire-rate limiter.
`timescale 1ns / 1ps

import shrl_pkg::*;

localparam int FRAC          = 8;
localparam int LARGE_MARGIN  = 105;
localparam int SMALL_MARGIN  = 15;
localparam int HEADROOM      = 5;
localparam int MAX_PRINTED   = 40;

typedef struct {
    logic               large_barrel;
    logic [15:0]        shot_heat;
    logic [19:0]        heat_limit;
    logic [15:0]        cool_per_second;
    logic [15:0]        cool_per_tick;
    logic signed [15:0] current_threshold;
    logic [15:0]        sync_idle_ticks;
    logic [15:0]        confirm_ticks;
} heat_cfg_t;

typedef struct {
    logic signed [15:0] current;
    logic signed [15:0] speed;
    logic signed [15:0] target;
    logic               ref_valid;
    logic [15:0]        ref_heat;
    logic [15:0]        desired;
    logic [15:0]        ceiling;
} tick_in_t;

typedef struct {
    logic [23:0] heat;
    logic [15:0] rate;
    det_mode_t   state;
    logic        shot;
} tick_out_t;

typedef struct {
    heat_cfg_t regs;
    int        items;
    int        send_idle_pct;
    int        recv_stall_pct;
} phase_t;

class heat_tick_scoreboard;
    heat_cfg_t   regs;
    det_mode_t   mode;
    logic [23:0] heat;
    logic [15:0] idle_cnt;
    logic [15:0] suspect_cnt;
    tick_out_t   expected_ticks[$];
    int          errors;
    int          results_seen;

    function new();
        regs = '{1'b0, 16'd2560, 20'd22528, 16'd6144, 16'd6, 16'sd3000, 16'd300, 16'd15};
        mode = DET_STOP;
        heat = '0;
        idle_cnt = '0;
        suspect_cnt = '0;
        errors = 0;
        results_seen = 0;
    endfunction

    function int pending();
        return expected_ticks.size();
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_LARGE_BARREL:      regs.large_barrel = data[0];
            CFG_SHOT_HEAT:         regs.shot_heat = data[15:0];
            CFG_HEAT_LIMIT:        regs.heat_limit = data[19:0];
            CFG_COOL_PER_SECOND:   regs.cool_per_second = data[15:0];
            CFG_COOL_PER_TICK:     regs.cool_per_tick = data[15:0];
            CFG_CURRENT_THRESHOLD: regs.current_threshold = data[15:0];
            CFG_SYNC_IDLE_TICKS:   regs.sync_idle_ticks = data[15:0];
            CFG_CONFIRM_TICKS:     regs.confirm_ticks = data[15:0];
            default: ;
        endcase
    endfunction

    // Advance the heat estimate and detector by one tick, then derive the rate.
    function void note_tick(tick_in_t t);
        tick_out_t   r;
        longint      q, qmax, d, margin, num, rate, limit_rate;
        int          spd, tgt;
        logic [23:0] reading;
        spd = t.speed;
        tgt = t.target;
        r.shot = 1'b0;
        if (idle_cnt != CNT_MAX) idle_cnt++;

        if (t.ref_valid) begin
            q = longint'(t.ref_heat) << FRAC;
            reading = (q > longint'(HEAT_MAX)) ? HEAT_MAX : q[23:0];
            if (heat < reading) heat = reading;
            if (idle_cnt > regs.sync_idle_ticks) heat = reading;
        end

        case (mode)
            DET_STOP: begin
                if (spd * 20 > tgt * 17) begin
                    mode = DET_PRECHECK;
                    suspect_cnt = '0;
                end
            end
            DET_PRECHECK: begin
                if (t.current >= regs.current_threshold) begin
                    mode = DET_SUSPECT;
                    suspect_cnt = '0;
                end
            end
            DET_SUSPECT: begin
                if (t.current < regs.current_threshold) begin
                    if (suspect_cnt != CNT_MAX) suspect_cnt++;
                    if (suspect_cnt > regs.confirm_ticks) begin
                        mode = DET_CONFIRM;
                        suspect_cnt = '0;
                    end
                end else begin
                    suspect_cnt = '0;
                end
            end
            default: begin
                q = longint'(heat) + longint'(regs.shot_heat);
                heat = (q > longint'(HEAT_MAX)) ? HEAT_MAX : q[23:0];
                idle_cnt = '0;
                mode = DET_PRECHECK;
                suspect_cnt = '0;
                r.shot = 1'b1;
            end
        endcase

        heat = (heat > regs.cool_per_tick) ? heat - regs.cool_per_tick : '0;

        q = longint'(heat);
        qmax = longint'(regs.heat_limit);
        d = longint'(regs.shot_heat);
        margin = longint'(regs.large_barrel ? LARGE_MARGIN : SMALL_MARGIN) << FRAC;
        if (q >= qmax - margin) begin
            // near the limit: stop, or hold at the rate cooling can absorb
            if (2 * q >= 2 * qmax - d) rate = 0;
            else if (d == 0) rate = longint'(RATE_MAX);
            else begin
                rate = ((longint'(regs.cool_per_second) << FRAC) * 4) / (5 * d);
                if (rate > longint'(RATE_MAX)) rate = longint'(RATE_MAX);
            end
        end else begin
            rate = longint'(t.desired);
            num = qmax - q - (longint'(HEADROOM) << FRAC);
            if (num <= 0) rate = 0;
            else if (d != 0) begin
                limit_rate = ((num * 10) << FRAC) / d;
                if (rate > limit_rate) rate = limit_rate;
            end
            if (rate > longint'(t.ceiling)) rate = longint'(t.ceiling);
            if (rate < 0) rate = 0;
        end

        r.heat = heat;
        r.rate = rate[15:0];
        r.state = mode;
        expected_ticks.push_back(r);
    endfunction

    task report(string msg);
        errors++;
        if (errors <= MAX_PRINTED) $display("MISMATCH: %s", msg);
    endtask

    task check_result(tick_out_t got);
        tick_out_t want;
        results_seen++;
        if (expected_ticks.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", results_seen));
            return;
        end
        want = expected_ticks.pop_front();
        if (got.heat !== want.heat)
            report($sformatf("result %0d heat_estimate %06h, want %06h",
                             results_seen, got.heat, want.heat));
        if (got.rate !== want.rate)
            report($sformatf("result %0d safe_rate %04h, want %04h",
                             results_seen, got.rate, want.rate));
        if (got.state !== want.state)
            report($sformatf("result %0d detector_state %0d, want %0d",
                             results_seen, got.state, want.state));
        if (got.shot !== want.shot)
            report($sformatf("result %0d shot_counted %0b, want %0b",
                             results_seen, got.shot, want.shot));
    endtask
endclass

module testbench;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_PHASE    = 4;
    localparam int PAUSE_PHASE   = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP    = 8'hFF;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic signed [15:0]    s_wheel_current = '0;
    logic signed [15:0]    s_wheel_speed = '0;
    logic signed [15:0]    s_target_speed = '0;
    logic                  s_ref_valid = 1'b0;
    logic [15:0]           s_ref_heat = '0;
    logic [15:0]           s_desired_rate = '0;
    logic [15:0]           s_rate_ceiling = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [23:0]           m_heat_estimate;
    logic [15:0]           m_safe_rate;
    logic [1:0]            m_detector_state;
    logic                  m_shot_counted;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;

    heat_tick_scoreboard heat_sb = new();
    int unsigned         cycle_count = 0;
    int                  recv_stall_pct = 0;
    int                  hold_req = 0;
    int                  hold_left = 0;
    int                  pulse_left = 0;
    int                  low_left = 0;
    phase_t              phases[6];

    shot_heat_estimator_rate_limiter_top #(.HEAT_FRAC_BITS(FRAC)) i_dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_mon
        tick_out_t got;
        if (aresetn && m_valid && m_ready) begin
            got.heat = m_heat_estimate;
            got.rate = m_safe_rate;
            got.state = det_mode_t'(m_detector_state);
            got.shot = m_shot_counted;
            heat_sb.check_result(got);
        end
    end

    // Drop valid, let every expected result drain, then let the block settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (heat_sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(heat_cfg_t c, bit with_unused);
        logic [CFG_IDX_W-1:0] idx[$];
        logic [CFG_DAT_W-1:0] val[$];
        idx = '{CFG_LARGE_BARREL, CFG_SHOT_HEAT, CFG_HEAT_LIMIT, CFG_COOL_PER_SECOND,
                CFG_COOL_PER_TICK, CFG_CURRENT_THRESHOLD, CFG_SYNC_IDLE_TICKS,
                CFG_CONFIRM_TICKS};
        val = '{CFG_DAT_W'(c.large_barrel), CFG_DAT_W'(c.shot_heat),
                CFG_DAT_W'(c.heat_limit), CFG_DAT_W'(c.cool_per_second),
                CFG_DAT_W'(c.cool_per_tick), {16'h0000, c.current_threshold},
                CFG_DAT_W'(c.sync_idle_ticks), CFG_DAT_W'(c.confirm_ticks)};
        if (with_unused) begin
            // out-of-range indexes must leave every register untouched
            idx.push_back(CFG_IDX_UNUSED);
            val.push_back('1);
            idx.push_back(CFG_IDX_TOP);
            val.push_back('1);
        end
        wait_drained();
        foreach (idx[i]) begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            cfg_valid <= 1'b1;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            heat_sb.note_config(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(tick_in_t t);
        s_wheel_current <= t.current;
        s_wheel_speed <= t.speed;
        s_target_speed <= t.target;
        s_ref_valid <= t.ref_valid;
        s_ref_heat <= t.ref_heat;
        s_desired_rate <= t.desired;
        s_rate_ceiling <= t.ceiling;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        heat_sb.note_tick(t);
    endtask

    task automatic send_fields(logic signed [15:0] cur, logic signed [15:0] spd,
                               logic signed [15:0] tgt, logic rv, logic [15:0] rh,
                               logic [15:0] des, logic [15:0] ceil);
        tick_in_t t;
        t = '{cur, spd, tgt, rv, rh, des, ceil};
        send_tick(t);
    endtask

    // Mostly well-formed shots: a current pulse, then low ticks, enough to confirm when confirm_ticks is at most 20.
    function automatic tick_in_t next_tick(heat_cfg_t c);
        tick_in_t t;
        int       thr, level;
        thr = c.current_threshold;
        t.ref_valid = ($urandom_range(99) < 12);
        level = int'(c.heat_limit >> FRAC) + int'($urandom_range(24)) - 16;
        if (level < 0) level = 0;
        t.ref_heat = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(level);
        t.desired = 16'($urandom);
        t.ceiling = 16'($urandom);
        if ($urandom_range(99) < 15) begin
            t.current = 16'($urandom);
            t.speed = 16'($urandom);
            t.target = 16'($urandom);
            return t;
        end
        level = $urandom_range(8000, 100);
        t.target = 16'(level);
        t.speed = 16'(level + int'($urandom_range(200)) - 50);
        if (pulse_left == 0 && low_left == 0) begin
            pulse_left = $urandom_range(3, 1);
            low_left = ((c.confirm_ticks > 20) ? 20 : int'(c.confirm_ticks))
                       + int'($urandom_range(3, 2));
            // cut roughly one sequence in ten short so it may fail to confirm
            if ($urandom_range(9) == 0) low_left = $urandom_range(low_left - 1, 1);
        end
        if (pulse_left > 0) begin
            pulse_left--;
            t.current = 16'(thr + int'($urandom_range(32767 - thr)));
        end else begin
            low_left--;
            t.current = (thr == -32768) ? 16'($urandom)
                                        : 16'(-32768 + int'($urandom_range(thr + 32767)));
        end
        return t;
    endfunction

    initial begin
        heat_cfg_t wide_cfg, hold_cfg, no_shot_cfg;
        wide_cfg    = '{1'b0, 16'd65535, 20'd22528, 16'd65535, 16'd0, 16'sd0, 16'd0, 16'd0};
        hold_cfg    = '{1'b1, 16'd1, 20'd100000, 16'd65535, 16'd1, 16'sd32767,
                        16'd65535, 16'd65535};
        no_shot_cfg = '{1'b0, 16'd0, 20'd1048575, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0};

        phases[0] = '{'{1'b0, 16'd2560, 20'd22528, 16'd6144, 16'd400, 16'sd3000,
                        16'd300, 16'd2}, 250, 0, 0};
        phases[1] = '{'{1'b1, 16'd5000, 20'd60000, 16'd1000, 16'd700, -16'sd100,
                        16'd20, 16'd3}, 250, 70, 0};
        phases[2] = '{'{1'b0, 16'd1, 20'd1048575, 16'd65535, 16'd65535, 16'sd32767,
                        16'd65535, 16'd1}, 200, 0, 70};
        phases[3] = '{'{1'b1, 16'd65535, 20'd0, 16'd0, 16'd0, 16'h8000,
                        16'd0, 16'd65535}, 150, 8, 8};
        phases[4] = '{'{1'b0, 16'd3000, 20'd30000, 16'd20000, 16'd500, 16'sd1000,
                        16'd5, 16'd4}, 250, 0, 0};
        phases[5] = '{'{1'b1, 16'd800, 20'd40000, 16'd500, 16'd150, 16'sd0,
                        16'd1000, 16'd1}, 200, 0, 70};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: detector leaves stop only on a strict speed margin,
        // heat saturates on a shot from a full reading, then snaps back.
        apply_settings(wide_cfg, 1'b1);
        send_fields(0, -32768, 32767, 1'b0, 16'd0, 16'd0, 16'd0);
        send_fields(0, 17, 20, 1'b0, 16'd0, 16'd0, 16'd0);
        send_fields(-1, 0, 0, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF);
        send_fields(0, 32767, -32768, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_fields(32767, 0, 0, 1'b0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_fields(-32768, 0, 0, 1'b0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_fields(0, 0, 0, 1'b0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_fields(-5, 0, 0, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF);
        send_fields(-5, 0, 0, 1'b0, 16'd0, 16'h1234, 16'h0010);
        send_fields(-5, 0, 0, 1'b0, 16'd0, 16'h0007, 16'hFFFF);
        send_fields(-5, 0, 0, 1'b1, 16'd80, 16'hFFFF, 16'hFFFF);

        // Hold band with tiny shot heat saturates the hold rate; a reading
        // below the estimate must not lower it outside the sync window.
        apply_settings(hold_cfg, 1'b0);
        send_fields(32767, 0, 0, 1'b1, 16'd390, 16'hFFFF, 16'hFFFF);
        send_fields(32766, 0, 0, 1'b1, 16'd391, 16'hFFFF, 16'hFFFF);
        send_fields(32766, 0, 0, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF);

        // Zero shot heat: hold rate tops out, and no heat-based limit below it.
        apply_settings(no_shot_cfg, 1'b0);
        send_fields(100, 0, 0, 1'b1, 16'd4090, 16'hFFFF, 16'hFFFF);
        send_fields(100, 0, 0, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF);
        send_fields(100, 0, 0, 1'b0, 16'd0, 16'd5, 16'd9);
        send_fields(100, 0, 0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        foreach (phases[p]) begin
            apply_settings(phases[p].regs, 1'b0);
            recv_stall_pct = phases[p].recv_stall_pct;
            for (int n = 0; n < phases[p].items; n++) begin
                // back up the output so the block stalls its input
                if (p == HOLD_PHASE && n == 60) hold_req = LONG_HOLD;
                if (p == PAUSE_PHASE && n == 100) wait_drained();
                if ($urandom_range(99) < phases[p].send_idle_pct) begin
                    s_valid <= 1'b0;
                    do @(posedge aclk); while ($urandom_range(99) < phases[p].send_idle_pct);
                end
                send_tick(next_tick(phases[p].regs));
            end
        end

        wait_drained();
        if (heat_sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
